// ===== hw/rtl/frua_pkg.sv =====
// Shared types and codes for the frame ring upload allocator.
package frua_pkg;

  // Width of a slot number on the ports.
  localparam int unsigned SLOT_W = 3;

  // Operation codes; code 7 is unused and acts as a no-op.
  typedef enum logic [2:0] {
    OP_BEGIN     = 3'd0,
    OP_ADVANCE   = 3'd1,
    OP_ALLOC     = 3'd2,
    OP_SET_FENCE = 3'd3,
    OP_GET_FENCE = 3'd4,
    OP_RESET_OFF = 3'd5,
    OP_CLEAR     = 3'd6
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BUSY      = 3'd1,
    ST_NOSPACE   = 3'd2,
    ST_BADINDEX  = 3'd3,
    ST_BADALIGN  = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the input payload
    logic exec;     // run the operation on the captured payload
    logic check;    // second allocate step: space check and offset bump
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_check;  // captured op is an allocate with a usable alignment
  } dp_stat_t;

endpackage

// ===== hw/rtl/frame_ring_upload_allocator.sv =====
// Top level of the frame ring upload allocator.
//
// Usage: a ring of SLOTS frame slots, each with a fence value and an upload
// offset. Commands arrive on the input channel (in_valid/in_ready) as an op
// code with its operands; every command gives exactly one result transfer on
// the output channel (out_valid/out_ready) with status, offset, fence_out and
// the current frame slot after the command.
// The capacity register is written through cfg_we/cfg_data while idle; the
// user is bound to this, and the block itself does not enforce it.
// The controller steps through an execute state, then a check state for an
// allocate with a power-of-two alignment, whose align step and space check
// run in separate states, and then a done state that offers the result.
// Only one command is in flight: a new command is taken after the last result.
// A stalled receiver holds the result steady and in_ready stays low until the
// result transfer completes.
// Reset clears every slot, sets capacity to zero and points the current slot
// at the last slot, so the first begin frame lands on slot zero.
module frame_ring_upload_allocator #(
  parameter int unsigned SLOTS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [63:0] completed_fence,
  input  logic [31:0] size_bytes,
  input  logic [16:0] alignment,
  input  logic [2:0]  slot_index,
  input  logic [63:0] fence_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] offset,
  output logic [63:0] fence_out,
  output logic [2:0]  frame_now
);

  frua_pkg::dp_cmd_t  cmd;
  frua_pkg::dp_stat_t stat;

  frua_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  frua_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .op              (op),
    .completed_fence (completed_fence),
    .size_bytes      (size_bytes),
    .alignment       (alignment),
    .slot_index      (slot_index),
    .fence_value     (fence_value),
    .status          (status),
    .offset          (offset),
    .fence_out       (fence_out),
    .frame_now       (frame_now)
  );

  // The two channels never offer a transfer in the same cycle.
  a_chan_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output offered together");

  // A result never appears in the cycle right after an input transfer.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result too early");

  // The reported frame slot is always inside the ring.
  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, frame_now} < 4'(SLOTS)))
    else $error("frame slot out of range");

  // A failed command reports no offset and no fence.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != frua_pkg::ST_OK)) |-> ((offset == '0) && (fence_out == '0)))
    else $error("failed command carries data");

endmodule

// ===== hw/rtl/frua_ctrl.sv =====
// Controller state machine for the frame ring upload allocator.
module frua_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  frua_pkg::dp_stat_t  stat,
  output frua_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_CHECK = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = stat.need_check ? S_CHECK : S_DONE;
      end
      S_CHECK: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Handshake and datapath commands.
  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_DONE);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.check   = (state == S_CHECK);

endmodule

// ===== hw/rtl/frua_dpath.sv =====
// Datapath for the frame ring upload allocator: slot state, align and space checks.
module frua_dpath #(
  parameter int unsigned SLOTS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  frua_pkg::dp_cmd_t             cmd,
  output frua_pkg::dp_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [31:0]                   cfg_data,
  input  logic [2:0]                    op,
  input  logic [63:0]                   completed_fence,
  input  logic [31:0]                   size_bytes,
  input  logic [16:0]                   alignment,
  input  logic [frua_pkg::SLOT_W-1:0]   slot_index,
  input  logic [63:0]                   fence_value,
  output logic [2:0]                    status,
  output logic [31:0]                   offset,
  output logic [63:0]                   fence_out,
  output logic [frua_pkg::SLOT_W-1:0]   frame_now
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  // Captured input payload.
  frua_pkg::op_t                 op_r;
  logic [63:0]                   completed_r;
  logic [31:0]                   size_r;
  logic [16:0]                   align_r;
  logic [frua_pkg::SLOT_W-1:0]   idx_r;
  logic [63:0]                   fval_r;

  // Slot state and configuration.
  logic [31:0]      capacity;
  logic [IDX_W-1:0] cur;
  logic [63:0]      slot_fence  [SLOTS];
  logic [32:0]      slot_offset [SLOTS];

  // Result registers and the aligned offset held between allocate steps.
  frua_pkg::status_t status_q;
  logic [31:0]       offset_q;
  logic [63:0]       fence_q;
  logic [33:0]       aligned_r;

  logic [IDX_W-1:0] next_slot;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] idx_lo;
  logic [63:0]      fence_rd;
  logic             begin_ok;
  logic             idx_ok;
  logic [16:0]      a_eff;
  logic [16:0]      a_mask;
  logic             pow2;
  logic [33:0]      aligned_next;
  logic [34:0]      end_sum;
  logic             fits;

  // Payload capture on an input transfer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= frua_pkg::op_t'(op);
      completed_r <= completed_fence;
      size_r      <= size_bytes;
      align_r     <= alignment;
      idx_r       <= slot_index;
      fval_r      <= fence_value;
    end
  end

  // Ring stepping and the one fence read port.
  assign next_slot = (cur == IDX_W'(SLOTS - 1)) ? '0 : cur + 1'b1;
  assign idx_lo    = idx_r[IDX_W-1:0];
  assign rd_idx    = (op_r == frua_pkg::OP_BEGIN) ? next_slot : idx_lo;
  assign fence_rd  = slot_fence[rd_idx];
  assign begin_ok  = (fence_rd <= completed_r);
  assign idx_ok    = ({1'b0, idx_r} < (frua_pkg::SLOT_W + 1)'(SLOTS));

  // Alignment: zero means one, and only powers of two are accepted.
  assign a_eff        = (align_r == '0) ? 17'd1 : align_r;
  assign a_mask       = a_eff - 17'd1;
  assign pow2         = ((a_eff & a_mask) == '0);
  assign aligned_next = ({1'b0, slot_offset[cur]} + 34'(a_mask)) & ~34'(a_mask);

  // Space check: the aligned end must not pass the capacity.
  assign end_sum = {1'b0, aligned_r} + 35'(size_r);
  assign fits    = (end_sum <= 35'(capacity));

  assign stat.need_check = (op_r == frua_pkg::OP_ALLOC) && pow2;

  // Slot state, current index and capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
      cur      <= IDX_W'(SLOTS - 1);
      for (int i = 0; i < SLOTS; i++) begin
        slot_fence[i]  <= '0;
        slot_offset[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (cmd.exec) begin
        unique case (op_r)
          frua_pkg::OP_BEGIN: begin
            if (begin_ok) begin
              cur                    <= next_slot;
              slot_offset[next_slot] <= '0;
            end
          end
          frua_pkg::OP_ADVANCE: begin
            cur                    <= next_slot;
            slot_offset[next_slot] <= '0;
          end
          frua_pkg::OP_SET_FENCE: begin
            if (idx_ok) begin
              slot_fence[idx_lo] <= fval_r;
            end
          end
          frua_pkg::OP_RESET_OFF: begin
            slot_offset[cur] <= '0;
          end
          frua_pkg::OP_CLEAR: begin
            cur <= IDX_W'(SLOTS - 1);
            for (int i = 0; i < SLOTS; i++) begin
              slot_fence[i]  <= '0;
              slot_offset[i] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.check && fits) begin
        slot_offset[cur] <= end_sum[32:0];
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q  <= frua_pkg::ST_OK;
      offset_q  <= '0;
      fence_q   <= '0;
      aligned_r <= aligned_next;
      unique case (op_r)
        frua_pkg::OP_BEGIN: begin
          if (!begin_ok) begin
            status_q <= frua_pkg::ST_BUSY;
          end
        end
        frua_pkg::OP_ALLOC: begin
          if (!pow2) begin
            status_q <= frua_pkg::ST_BADALIGN;
          end
        end
        frua_pkg::OP_SET_FENCE: begin
          if (!idx_ok) begin
            status_q <= frua_pkg::ST_BADINDEX;
          end
        end
        frua_pkg::OP_GET_FENCE: begin
          if (idx_ok) begin
            fence_q <= fence_rd;
          end else begin
            status_q <= frua_pkg::ST_BADINDEX;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.check) begin
      if (fits) begin
        offset_q <= aligned_r[31:0];
      end else begin
        status_q <= frua_pkg::ST_NOSPACE;
      end
    end
  end

  assign status    = status_q;
  assign offset    = offset_q;
  assign fence_out = fence_q;
  assign frame_now = frua_pkg::SLOT_W'(cur);

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the frame ring upload allocator.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned NSLOTS     = 3;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned CHUNK_LEN  = 250;
  // Op code 7 has no enum member; the block treats it as a no-op.
  localparam logic [2:0]  OP_NOP     = 3'd7;
  localparam logic [63:0] ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] completed;
    logic [31:0] size;
    logic [16:0] align;
    logic [2:0]  slot;
    logic [63:0] fence;
  } ring_cmd_t;

  typedef struct packed {
    frua_pkg::status_t status;
    logic [31:0]       offset;
    logic [63:0]       fence;
    logic [2:0]        frame;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op = '0;
  logic [63:0] completed_fence = '0;
  logic [31:0] size_bytes = '0;
  logic [16:0] alignment = '0;
  logic [2:0]  slot_index = '0;
  logic [63:0] fence_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] offset;
  logic [63:0] fence_out;
  logic [2:0]  frame_now;

  // Commands waiting to be offered, and results owed by the block.
  ring_cmd_t    cmd_backlog[$];
  ring_result_t due_results[$];

  // Shadow copy of the ring state and the capacity register.
  logic [63:0] fence_mem [NSLOTS];
  logic [32:0] offset_mem [NSLOTS];
  logic [2:0]  slot_now;
  logic [31:0] capacity_reg;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned stall_asks = 0;
  int unsigned stall_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;

  frame_ring_upload_allocator #(
    .SLOTS(NSLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .completed_fence(completed_fence),
    .size_bytes(size_bytes),
    .alignment(alignment),
    .slot_index(slot_index),
    .fence_value(fence_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .offset(offset),
    .fence_out(fence_out),
    .frame_now(frame_now)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Zero every slot and point at the last one, as reset and clear do.
  function automatic void ring_clear();
    for (int s = 0; s < NSLOTS; s++) begin
      fence_mem[s]  = '0;
      offset_mem[s] = '0;
    end
    slot_now = 3'(NSLOTS - 1);
  endfunction

  // Apply one command to the shadow ring and return the result it owes.
  function automatic ring_result_t ring_apply(ring_cmd_t c);
    ring_result_t r;
    logic [2:0]   nxt;
    logic [16:0]  a;
    logic [63:0]  amask;
    logic [63:0]  aligned;
    logic [63:0]  sum;
    r.status = frua_pkg::ST_OK;
    r.offset = '0;
    r.fence  = '0;
    nxt = (slot_now >= NSLOTS - 1) ? 3'd0 : slot_now + 3'd1;
    unique case (c.op)
      frua_pkg::OP_BEGIN: begin
        if (fence_mem[nxt] > c.completed) begin
          r.status = frua_pkg::ST_BUSY;
        end else begin
          slot_now = nxt;
          offset_mem[nxt] = '0;
        end
      end
      frua_pkg::OP_ADVANCE: begin
        slot_now = nxt;
        offset_mem[nxt] = '0;
      end
      frua_pkg::OP_ALLOC: begin
        a = (c.align == '0) ? 17'd1 : c.align;
        if ((a & (a - 17'd1)) != '0) begin
          r.status = frua_pkg::ST_BADALIGN;
        end else begin
          amask   = {47'd0, a} - 64'd1;
          aligned = ({31'd0, offset_mem[slot_now]} + amask) & ~amask;
          if (aligned > {32'd0, capacity_reg} ||
              {32'd0, c.size} > {32'd0, capacity_reg} - aligned) begin
            r.status = frua_pkg::ST_NOSPACE;
          end else begin
            r.offset = aligned[31:0];
            sum = aligned + {32'd0, c.size};
            offset_mem[slot_now] = sum[32:0];
          end
        end
      end
      frua_pkg::OP_SET_FENCE: begin
        if (c.slot >= NSLOTS) r.status = frua_pkg::ST_BADINDEX;
        else fence_mem[c.slot] = c.fence;
      end
      frua_pkg::OP_GET_FENCE: begin
        if (c.slot >= NSLOTS) r.status = frua_pkg::ST_BADINDEX;
        else r.fence = fence_mem[c.slot];
      end
      frua_pkg::OP_RESET_OFF: offset_mem[slot_now] = '0;
      frua_pkg::OP_CLEAR: ring_clear();
      default: ;
    endcase
    r.frame = slot_now;
    return r;
  endfunction

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  task automatic queue_cmd(input logic [2:0] c_op, input logic [63:0] c_done,
                           input logic [31:0] c_size, input logic [16:0] c_align,
                           input logic [2:0] c_slot, input logic [63:0] c_fence);
    ring_cmd_t c;
    c.op = c_op;
    c.completed = c_done;
    c.size = c_size;
    c.align = c_align;
    c.slot = c_slot;
    c.fence = c_fence;
    cmd_backlog.push_back(c);
  endtask

  // Mostly well-formed frame traffic; unused fields carry random noise.
  task automatic fill_random(input int unsigned count);
    ring_cmd_t   c;
    int unsigned pick;
    int unsigned r;
    for (int unsigned k = 0; k < count; k++) begin
      c.completed = {$urandom, $urandom};
      c.size = $urandom;
      c.align = 17'($urandom);
      c.slot = 3'($urandom);
      c.fence = {$urandom, $urandom};
      pick = $urandom_range(99);
      r = $urandom_range(99);
      if (pick < 40) begin
        c.op = frua_pkg::OP_ALLOC;
        if (r < 70)
          c.align = 17'd1 << $urandom_range(($urandom_range(3) == 0) ? 16 : 6);
        else if (r < 82)
          c.align = '0;
        r = $urandom_range(99);
        if (r < 55) c.size = $urandom_range(capacity_reg >> 3);
        else if (r < 80) c.size = $urandom_range(16);
        else if (r >= 90) c.size = capacity_reg;
      end else if (pick < 56) begin
        c.op = frua_pkg::OP_BEGIN;
        if (r < 80) c.completed = 64'($urandom_range(60));
      end else if (pick < 63) begin
        c.op = frua_pkg::OP_ADVANCE;
      end else if (pick < 84) begin
        c.op = (pick < 74) ? frua_pkg::OP_SET_FENCE : frua_pkg::OP_GET_FENCE;
        if (r < 80) c.slot = 3'($urandom_range(NSLOTS - 1));
        if ($urandom_range(99) < 85) c.fence = 64'($urandom_range(50));
      end else if (pick < 90) begin
        c.op = frua_pkg::OP_RESET_OFF;
      end else if (pick < 93) begin
        c.op = frua_pkg::OP_CLEAR;
      end else begin
        c.op = OP_NOP;
      end
      cmd_backlog.push_back(c);
    end
  endtask

  // Wait until every command has been taken and every result has come back.
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // The block is idle whenever this is called.
  task automatic write_capacity(input logic [31:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    capacity_reg = value;
    @(negedge clk);
  endtask

  // Command driver: offer the backlog head, predict on each input transfer.
  always @(posedge clk) begin : cmd_driver
    ring_cmd_t c;
    logic      taken;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        due_results.push_back(ring_apply(cmd_backlog[0]));
        void'(cmd_backlog.pop_front());
      end
      if (!in_valid || taken) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
          c = cmd_backlog[0];
          in_valid        <= 1'b1;
          op              <= c.op;
          completed_fence <= c.completed;
          size_bytes      <= c.size;
          alignment       <= c.align;
          slot_index      <= c.slot;
          fence_value     <= c.fence;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started on request from the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (stall_asks != stall_served) begin
      stall_served <= stall_asks;
      hold_left    <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: check each result transfer against the oldest one owed.
  always @(posedge clk) begin : result_monitor
    ring_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected result", {61'd0, status}, '0);
        end else begin
          want = due_results.pop_front();
          if (status !== want.status)
            flag_mismatch("status", {61'd0, status}, {61'd0, want.status});
          if (offset !== want.offset)
            flag_mismatch("offset", {32'd0, offset}, {32'd0, want.offset});
          if (fence_out !== want.fence)
            flag_mismatch("fence_out", fence_out, want.fence);
          if (frame_now !== want.frame)
            flag_mismatch("frame_now", {61'd0, frame_now}, {61'd0, want.frame});
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] cap;
    capacity_reg = '0;
    ring_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: fences, busy slot, alignment and space edges, bad indexes.
    write_capacity(32'd256);
    queue_cmd(frua_pkg::OP_GET_FENCE, '0, '0, '0, 3'd0, '0);
    queue_cmd(frua_pkg::OP_ALLOC, '0, 32'd0, 17'd0, '0, '0);
    queue_cmd(frua_pkg::OP_BEGIN, 64'd0, '0, '0, '0, '0);
    queue_cmd(frua_pkg::OP_SET_FENCE, '0, '0, '0, 3'd1, 64'd5);
    queue_cmd(frua_pkg::OP_BEGIN, 64'd4, '0, '0, '0, '0);
    queue_cmd(frua_pkg::OP_BEGIN, 64'd5, '0, '0, '0, '0);
    queue_cmd(frua_pkg::OP_ALLOC, '0, 32'd10, 17'd1, '0, '0);
    queue_cmd(frua_pkg::OP_ALLOC, '0, 32'd1, 17'd16, '0, '0);
    queue_cmd(frua_pkg::OP_ALLOC, '0, 32'd1, 17'd3, '0, '0);
    queue_cmd(frua_pkg::OP_ALLOC, '0, 32'd0, 17'h10000, '0, '0);
    queue_cmd(frua_pkg::OP_ALLOC, '0, 32'd239, 17'd1, '0, '0);
    queue_cmd(frua_pkg::OP_ALLOC, '0, 32'd1, 17'd0, '0, '0);
    queue_cmd(frua_pkg::OP_ALLOC, '0, 32'd0, 17'd0, '0, '0);
    queue_cmd(frua_pkg::OP_RESET_OFF, '0, '0, '0, '0, '0);
    queue_cmd(frua_pkg::OP_ALLOC, '0, ALL_ONES32, 17'd0, '0, '0);
    queue_cmd(frua_pkg::OP_SET_FENCE, '0, '0, '0, 3'd7, ALL_ONES64);
    queue_cmd(frua_pkg::OP_SET_FENCE, '0, '0, '0, 3'(NSLOTS), 64'd1);
    queue_cmd(frua_pkg::OP_GET_FENCE, '0, '0, '0, 3'(NSLOTS), '0);
    queue_cmd(frua_pkg::OP_SET_FENCE, '0, '0, '0, 3'd2, ALL_ONES64);
    queue_cmd(frua_pkg::OP_GET_FENCE, '0, '0, '0, 3'd2, '0);
    queue_cmd(frua_pkg::OP_ADVANCE, '0, '0, '0, '0, '0);
    queue_cmd(frua_pkg::OP_BEGIN, ALL_ONES64, '0, '0, '0, '0);
    queue_cmd(frua_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
    queue_cmd(frua_pkg::OP_GET_FENCE, '0, '0, '0, 3'd1, '0);
    queue_cmd(OP_NOP, ALL_ONES64, ALL_ONES32, 17'h1FFFF, 3'd7, ALL_ONES64);
    queue_cmd(frua_pkg::OP_ALLOC, '0, 32'd0, 17'h1FFFF, '0, '0);
    wait_drained();

    // Random part in chunks, each with its own capacity and idling pattern.
    for (int unsigned i = 0; i < 8; i++) begin
      case (i)
        0: cap = 32'd0;
        1: cap = 32'd64;
        2: cap = ALL_ONES32;
        3: cap = 32'd4096;
        4: cap = $urandom;
        5: cap = 32'd300;
        6: cap = 32'h0010_0000;
        default: cap = ALL_ONES32;
      endcase
      write_capacity(cap);
      send_idle = (i < 3) ? 18 : (i < 6) ? 53 : 0;
      recv_idle = (i < 3) ? 53 : (i < 6) ? 18 : 0;
      // At full capacity, fill a region to the last byte and step past the end.
      if (i == 2) begin
        queue_cmd(frua_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
        queue_cmd(frua_pkg::OP_ALLOC, '0, ALL_ONES32, 17'd0, '0, '0);
        queue_cmd(frua_pkg::OP_ALLOC, '0, 32'd0, 17'd0, '0, '0);
        queue_cmd(frua_pkg::OP_ALLOC, '0, 32'd0, 17'd2, '0, '0);
      end
      fill_random(CHUNK_LEN);
      // Hold the receiver off while the sender keeps offering commands.
      if (i == 1) stall_asks++;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/frua_pkg.sv
hw/rtl/frua_ctrl.sv
hw/rtl/frua_dpath.sv
hw/rtl/frame_ring_upload_allocator.sv
tb/tb_top.sv
